// ===== rtl/core/rrb_pkg.sv =====
// Shared constants for the receive ring buffer line reader.
package rrb_pkg;

  // Field widths
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LIMIT_W = 7;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned LEVEL_W = 6;
  // Width for fill arithmetic (index plus one depth)
  localparam int unsigned CALC_W  = 7;

  // Command codes
  localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LINE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd3;

  // Special characters
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

endpackage

// ===== rtl/core/rrb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rx_ring_buffer_line_reader.sv =====
// Top level: receive byte ring with push, byte read, line read and flush.
//
// Channel   | Direction | Handshake                   | Payload
// ----------+-----------+-----------------------------+------------------------------------
// command   | in        | start_i & !busy_o           | kind_i, rx_byte_i, line_limit_i
// result    | out       | result_valid_o (one cycle)  | data_byte_o, data_valid_o, last_o,
//           |           |                             | line_count_o, fill_level_o, dropped_o
//
// Push, flush and a read of an empty ring finish in ST_IDLE; the result shows
// the cycle after the transaction and busy_o never rises.
// A byte read that pops passes through ST_RD for the ring RAM read latency.
// A line read alternates ST_LREQ and ST_LDAT for each popped byte, as the pop loop waits on
// the RAM read latency. Reset clears both indices; the RAM needs no clear.
// Results cannot be stalled: each one is on the ports for exactly one cycle.
module rx_ring_buffer_line_reader
  import rrb_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [BYTE_W-1:0]  rx_byte_i,
  input  logic [LIMIT_W-1:0] line_limit_i,
  output logic               result_valid_o,
  output logic [BYTE_W-1:0]  data_byte_o,
  output logic               data_valid_o,
  output logic               last_o,
  output logic [COUNT_W-1:0] line_count_o,
  output logic [LEVEL_W-1:0] fill_level_o,
  output logic               dropped_o
);

  localparam int unsigned IW = $clog2(RING_DEPTH);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_LREQ = 2'd2;
  localparam logic [1:0] ST_LDAT = 2'd3;

  function automatic logic [IW-1:0] advance(input logic [IW-1:0] idx);
    return (idx == IW'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  logic [1:0]         state_q, state_d;
  logic [IW-1:0]      wr_q, wr_d;
  logic [IW-1:0]      rd_q, rd_d;
  logic [LIMIT_W-1:0] maxkeep_q, maxkeep_d;
  logic [LIMIT_W-1:0] count_q, count_d;
  logic               lf_q, lf_d;
  // Pending kept byte of a line read, emitted once its successor is known
  logic               pend_v_q, pend_v_d;
  logic [BYTE_W-1:0]  pend_byte_q, pend_byte_d;
  logic [COUNT_W-1:0] pend_cnt_q, pend_cnt_d;
  logic [LEVEL_W-1:0] pend_lvl_q, pend_lvl_d;
  // Result registers
  logic               res_v_q, res_v_d;
  logic [BYTE_W-1:0]  res_byte_q, res_byte_d;
  logic               res_dv_q, res_dv_d;
  logic               res_last_q, res_last_d;
  logic [COUNT_W-1:0] res_cnt_q, res_cnt_d;
  logic [LEVEL_W-1:0] res_lvl_q, res_lvl_d;
  logic               res_drop_q, res_drop_d;

  logic               accept;
  logic [IW-1:0]      wr_nxt;
  logic               full;
  logic [CALC_W-1:0]  fill_now;
  logic               ram_we;
  logic               ram_re;
  logic [BYTE_W-1:0]  ram_rdata;
  logic [IW-1:0]      rd_adv;
  logic [COUNT_W-1:0] count_inc;

  // Ring storage
  rrb_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_q),
    .wdata_i(rx_byte_i),
    .re_i   (ram_re),
    .raddr_i(rd_q),
    .rdata_o(ram_rdata)
  );

  // Index arithmetic
  assign accept    = start_i && !busy_o;
  assign wr_nxt    = advance(wr_q);
  assign full      = (wr_nxt == rd_q);
  assign rd_adv    = advance(rd_q);
  assign fill_now  = (wr_q >= rd_q) ? (CALC_W'(wr_q) - CALC_W'(rd_q))
                                    : (CALC_W'(wr_q) + CALC_W'(RING_DEPTH) - CALC_W'(rd_q));
  assign count_inc = COUNT_W'(count_q + 1'b1);

  assign ram_we = accept && (kind_i == KIND_PUSH) && !full;
  assign ram_re = (accept && (kind_i == KIND_READ) && (fill_now != '0))
               || ((state_q == ST_LREQ) && (fill_now != '0)
                   && (count_q < maxkeep_q) && !lf_q);

  // Sequencer and result formation
  always_comb begin
    state_d     = state_q;
    wr_d        = wr_q;
    rd_d        = rd_q;
    maxkeep_d   = maxkeep_q;
    count_d     = count_q;
    lf_d        = lf_q;
    pend_v_d    = pend_v_q;
    pend_byte_d = pend_byte_q;
    pend_cnt_d  = pend_cnt_q;
    pend_lvl_d  = pend_lvl_q;
    res_v_d     = 1'b0;
    res_byte_d  = '0;
    res_dv_d    = 1'b0;
    res_last_d  = 1'b1;
    res_cnt_d   = '0;
    res_lvl_d   = LEVEL_W'(fill_now);
    res_drop_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind_i)
            KIND_PUSH: begin
              res_v_d = 1'b1;
              if (full) begin
                res_drop_d = 1'b1;
              end else begin
                wr_d      = wr_nxt;
                res_lvl_d = LEVEL_W'(fill_now + 1'b1);
              end
            end
            KIND_READ: begin
              if (fill_now == '0) begin
                res_v_d = 1'b1;
              end else begin
                rd_d    = rd_adv;
                state_d = ST_RD;
              end
            end
            KIND_LINE: begin
              maxkeep_d = (line_limit_i == '0) ? '0 : line_limit_i - 1'b1;
              count_d   = '0;
              lf_d      = 1'b0;
              pend_v_d  = 1'b0;
              state_d   = ST_LREQ;
            end
            default: begin
              wr_d      = '0;
              rd_d      = '0;
              res_v_d   = 1'b1;
              res_lvl_d = '0;
            end
          endcase
        end
      end
      ST_RD: begin
        res_v_d    = 1'b1;
        res_byte_d = ram_rdata;
        res_dv_d   = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_LREQ: begin
        if (ram_re) begin
          rd_d    = rd_adv;
          state_d = ST_LDAT;
        end else begin
          // Loop done: flush the pending byte as last, or report an empty line
          res_v_d = 1'b1;
          if (pend_v_q) begin
            res_byte_d = pend_byte_q;
            res_dv_d   = 1'b1;
            res_cnt_d  = pend_cnt_q;
          end
          state_d = ST_IDLE;
        end
      end
      ST_LDAT: begin
        state_d = ST_LREQ;
        if (ram_rdata != CH_CR) begin
          if (pend_v_q) begin
            res_v_d    = 1'b1;
            res_byte_d = pend_byte_q;
            res_dv_d   = 1'b1;
            res_last_d = 1'b0;
            res_cnt_d  = pend_cnt_q;
            res_lvl_d  = pend_lvl_q;
          end
          count_d     = count_q + 1'b1;
          pend_v_d    = 1'b1;
          pend_byte_d = ram_rdata;
          pend_cnt_d  = count_inc;
          pend_lvl_d  = LEVEL_W'(fill_now);
          lf_d        = (ram_rdata == CH_LF);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wr_q     <= '0;
      rd_q     <= '0;
      pend_v_q <= 1'b0;
      lf_q     <= 1'b0;
      count_q  <= '0;
      res_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      wr_q     <= wr_d;
      rd_q     <= rd_d;
      pend_v_q <= pend_v_d;
      lf_q     <= lf_d;
      count_q  <= count_d;
      res_v_q  <= res_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    maxkeep_q   <= maxkeep_d;
    pend_byte_q <= pend_byte_d;
    pend_cnt_q  <= pend_cnt_d;
    pend_lvl_q  <= pend_lvl_d;
    res_byte_q  <= res_byte_d;
    res_dv_q    <= res_dv_d;
    res_last_q  <= res_last_d;
    res_cnt_q   <= res_cnt_d;
    res_lvl_q   <= res_lvl_d;
    res_drop_q  <= res_drop_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = res_v_q;
  assign data_byte_o    = res_byte_q;
  assign data_valid_o   = res_dv_q;
  assign last_o         = res_last_q;
  assign line_count_o   = res_cnt_q;
  assign fill_level_o   = res_lvl_q;
  assign dropped_o      = res_drop_q;

  // Ring never holds more than RING_DEPTH-1 bytes
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_now < CALC_W'(RING_DEPTH))
    else $error("ring fill exceeds capacity");

  // Push and flush answer in the next cycle
  a_push_flush_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ((kind_i == KIND_PUSH) || (kind_i == KIND_FLUSH))) |=> result_valid_o && last_o)
    else $error("missing push/flush result");

  // RAM data is consumed only in the cycle after a read was issued
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RD) || (state_q == ST_LDAT)) |-> $past(ram_re))
    else $error("RAM data used without a read");

  // A result without a popped byte carries a zero byte and a zero line count
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !data_valid_o) |-> (data_byte_o == '0) && (line_count_o == '0))
    else $error("empty result carries data");

  // A line read never keeps more bytes than its limit allows
  a_keep_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LREQ) |-> (count_q <= maxkeep_q))
    else $error("line read over its limit");

endmodule
